>>> hdl/display_frame_receiver_assert.svh
// Assertion macros for the display frame receiver.
// Used by the top level; expects clk and rst in scope.
`ifndef DISPLAY_FRAME_RECEIVER_ASSERT_SVH
`define DISPLAY_FRAME_RECEIVER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// antecedent holds -> consequent holds in the same cycle
`define DFR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("display_frame_receiver: check failed");
// antecedent holds -> consequent holds in the next cycle
`define DFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("display_frame_receiver: check failed");
`else
`define DFR_ASSERT_IMP(lbl, ante, cons)
`define DFR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> hdl/dfr_pkg.sv
// Package for the display frame receiver: types, frame constants and
// symbol decode functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dfr_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] word_t;

  localparam byte_t CMD_TYPE    = 8'h41;
  localparam byte_t CMD_STATUS  = 8'h01;
  localparam byte_t DIGIT_LO    = 8'h30;
  localparam byte_t DIGIT_HI    = 8'h39;
  localparam byte_t POINT_LO    = 8'hA0;
  localparam byte_t POINT_HI    = 8'hA9;
  localparam byte_t POINT_SHIFT = POINT_LO - DIGIT_LO;
  localparam byte_t CH_POINT    = 8'h2E;
  localparam byte_t CH_ERROR    = 8'h45;
  localparam byte_t CH_UNKNOWN  = 8'h3F;

  // Index of the checksum byte within each payload
  localparam logic [2:0] STR_CSUM_IDX = 3'd6;
  localparam logic [2:0] CMD_CSUM_IDX = 3'd1;

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_HEAD = 4'b0010,
    PH_CMD  = 4'b0100,
    PH_STR  = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    RP_START  = 2'd0,
    RP_ADDR   = 2'd1,
    RP_STATUS = 2'd2,
    RP_CSUM   = 2'd3
  } reply_pos_t;

  typedef struct packed {
    logic              disp;
    logic              stat;
    byte_t             matrix;
    logic [3:0][15:0]  seg;
    byte_t             status;
  } evt_t;

  function automatic word_t seg_word(byte_t s);
    word_t w;
    if (s >= DIGIT_LO && s <= DIGIT_HI) begin
      w = {8'h00, s};
    end else if (s >= POINT_LO && s <= POINT_HI) begin
      w = {CH_POINT, s - POINT_SHIFT};
    end else begin
      w = {8'h00, CH_ERROR};
    end
    return w;
  endfunction

  function automatic byte_t matrix_of(byte_t m);
    byte_t r;
    unique case (m)
      "T", "H", "D", "P", "F", "C", "S", "Q", "O", "Z": r = m;
      default: r = CH_UNKNOWN;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/dfr_rx_if.sv
// Byte input channel of the display frame receiver.
// Depends on dfr_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface dfr_rx_if;
  import dfr_pkg::*;
  logic  valid;
  logic  ready;
  byte_t rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

>>> hdl/dfr_res_if.sv
// Result channel of the display frame receiver.
// Depends on dfr_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface dfr_res_if;
  import dfr_pkg::*;
  logic  valid;
  logic  ready;
  logic  result_kind;
  byte_t matrix_char;
  word_t seg_word0;
  word_t seg_word1;
  word_t seg_word2;
  word_t seg_word3;
  byte_t reply_byte;
  logic  last;
  modport source (output valid, output result_kind, output matrix_char,
                  output seg_word0, output seg_word1, output seg_word2,
                  output seg_word3, output reply_byte, output last,
                  input ready);
  modport sink (input valid, input result_kind, input matrix_char,
                input seg_word0, input seg_word1, input seg_word2,
                input seg_word3, input reply_byte, input last,
                output ready);
endinterface
`default_nettype wire

>>> hdl/dfr_parser.sv
// Frame parser: hunts for the start byte, checks address, type and
// checksum, and flags a good display or status frame. Depends on dfr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dfr_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  dfr_pkg::byte_t rx_byte,
  input  dfr_pkg::byte_t device_address,
  output dfr_pkg::evt_t  evt
);
  import dfr_pkg::*;

  phase_t     phase, phase_next;
  logic [2:0] count, count_next;
  byte_t      sum, sum_next, sum_add;
  logic       reset_flag, reset_flag_next;
  byte_t      frame [8];
  logic       frame_we;
  logic       restart;

  always_comb begin
    phase_next      = phase;
    count_next      = count;
    sum_next        = sum;
    reset_flag_next = reset_flag;
    frame_we        = 1'b0;
    restart         = 1'b0;
    sum_add         = sum + rx_byte;
    evt.disp        = 1'b0;
    evt.stat        = 1'b0;
    evt.matrix      = matrix_of(frame[1]);
    for (int k = 0; k < 4; k++) begin
      evt.seg[k] = seg_word(frame[k + 2]);
    end
    evt.status = {6'b0, reset_flag, 1'b1};

    if (take) begin
      unique case (phase)
        PH_HUNT: begin
          if (rx_byte == 8'h00) begin
            phase_next = PH_HEAD;
            count_next = 3'd0;
            sum_next   = 8'h00;
          end
        end
        PH_HEAD: begin
          priority if (rx_byte == 8'h00) begin
            restart = 1'b1;
          end else if (count == 3'd0) begin
            frame_we   = 1'b1;
            sum_next   = sum_add;
            count_next = 3'd1;
          end else if (frame[0] != device_address || rx_byte > CMD_TYPE) begin
            restart = 1'b1;
          end else begin
            phase_next = (rx_byte == CMD_TYPE) ? PH_CMD : PH_STR;
            count_next = 3'd0;
            sum_next   = sum_add;
          end
        end
        PH_CMD, PH_STR: begin
          priority if (rx_byte == 8'h00) begin
            restart = 1'b1;
          end else if (count < ((phase == PH_STR) ? STR_CSUM_IDX : CMD_CSUM_IDX)) begin
            frame_we   = 1'b1;
            sum_next   = sum_add;
            count_next = count + 3'd1;
          end else begin
            // checksum byte: the frame ends here either way
            restart = 1'b1;
            if (8'h00 - sum == rx_byte) begin
              if (phase == PH_STR) begin
                evt.disp = 1'b1;
              end else if (frame[0] == CMD_STATUS) begin
                evt.stat        = 1'b1;
                reset_flag_next = 1'b0;
              end
            end
          end
        end
        default: restart = 1'b1;
      endcase
    end

    if (restart) begin
      phase_next = PH_HUNT;
      count_next = 3'd0;
      sum_next   = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      count      <= 3'd0;
      sum        <= 8'h00;
      reset_flag <= 1'b1;
    end else begin
      phase      <= phase_next;
      count      <= count_next;
      sum        <= sum_next;
      reset_flag <= reset_flag_next;
    end
  end

  // Payload bytes land at their count; the command overwrites the address slot
  always_ff @(posedge clk) begin
    if (frame_we) begin
      frame[count] <= rx_byte;
    end
  end

endmodule
`default_nettype wire

>>> hdl/display_frame_receiver.sv
// Display frame receiver top level: address register, parser and result
// register with the status reply sequencer. Depends on dfr_pkg, dfr_rx_if,
// dfr_res_if, dfr_parser and display_frame_receiver_assert.svh.
//
//   channel  dir  payload                                    handshake
//   rx       in   rx_byte                                    valid/ready
//   res      out  result_kind, matrix_char, seg_word0..3,    valid/ready
//                 reply_byte, last
//   cfg      in   cfg_wr_data (device_address)               cfg_wr_en
//
// One byte is taken per cycle while rx.ready is high; a result appears in the
// cycle after the byte that completes a good frame. A status command gives four
// result items, one per output handshake, and rx.ready stays low until the last
// is taken. rst is synchronous: parser hunts, reset flag set, device_address
// = 1. A stall on res holds the result register and, with it, rx.ready.
`timescale 1ns / 1ps
`default_nettype none
`include "display_frame_receiver_assert.svh"
module display_frame_receiver (
  input  logic           clk,
  input  logic           rst,
  dfr_rx_if.sink         rx,
  dfr_res_if.source      res,
  input  logic           cfg_wr_en,
  input  dfr_pkg::byte_t cfg_wr_data
);
  import dfr_pkg::*;

  byte_t      device_address;
  evt_t       evt;
  logic       take;
  logic       out_valid;
  logic       out_kind;
  byte_t      out_matrix;
  word_t      out_seg [4];
  byte_t      out_reply;
  logic       out_last;
  reply_pos_t reply_pos, reply_pos_next;
  byte_t      reply_addr;
  byte_t      reply_status;
  byte_t      reply_next;
  logic       reply_more;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 8'h01;
    end else if (cfg_wr_en) begin
      device_address <= cfg_wr_data;
    end
  end

  // Hold input while reply bytes remain beyond the one on show
  assign reply_more = out_valid && out_kind && (reply_pos != RP_CSUM);
  assign rx.ready   = !reply_more && (!out_valid || res.ready);
  assign take       = rx.valid && rx.ready;

  dfr_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .rx_byte        (rx.rx_byte),
    .device_address (device_address),
    .evt            (evt)
  );

  assign reply_pos_next = reply_pos_t'(reply_pos + 2'd1);

  always_comb begin
    unique case (reply_pos_next)
      RP_START:  reply_next = 8'h00;
      RP_ADDR:   reply_next = reply_addr;
      RP_STATUS: reply_next = reply_status;
      RP_CSUM:   reply_next = 8'h00 - (reply_addr + reply_status);
      default:   reply_next = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      reply_pos <= RP_START;
    end else begin
      priority if (evt.disp) begin
        out_valid <= 1'b1;
      end else if (evt.stat) begin
        out_valid <= 1'b1;
        reply_pos <= RP_START;
      end else if (out_valid && res.ready) begin
        if (reply_more) begin
          reply_pos <= reply_pos_next;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (evt.disp) begin
      out_kind   <= 1'b0;
      out_matrix <= evt.matrix;
      for (int k = 0; k < 4; k++) begin
        out_seg[k] <= evt.seg[k];
      end
      out_reply <= 8'h00;
      out_last  <= 1'b1;
    end else if (evt.stat) begin
      out_kind   <= 1'b1;
      out_matrix <= 8'h00;
      for (int k = 0; k < 4; k++) begin
        out_seg[k] <= 16'h0000;
      end
      out_reply    <= 8'h00;
      out_last     <= 1'b0;
      reply_addr   <= device_address;
      reply_status <= evt.status;
    end else if (out_valid && res.ready && reply_more) begin
      // advance to the next reply byte
      out_reply <= reply_next;
      out_last  <= (reply_pos_next == RP_CSUM);
    end
  end

  assign res.valid       = out_valid;
  assign res.result_kind = out_kind;
  assign res.matrix_char = out_matrix;
  assign res.seg_word0   = out_seg[0];
  assign res.seg_word1   = out_seg[1];
  assign res.seg_word2   = out_seg[2];
  assign res.seg_word3   = out_seg[3];
  assign res.reply_byte  = out_reply;
  assign res.last        = out_last;

  `DFR_ASSERT_IMP(a_reply_blocks_input, res.valid && res.result_kind && !res.last, !rx.ready)
  `DFR_ASSERT_NEXT(a_reply_continues, res.valid && res.ready && res.result_kind && !res.last, res.valid && res.result_kind)
  `DFR_ASSERT_IMP(a_display_single, res.valid && !res.result_kind, res.last)
  `DFR_ASSERT_IMP(a_one_event_kind, 1'b1, !(evt.disp && evt.stat))

endmodule
`default_nettype wire
